FILE: rtl/mch_pkg.sv
// Package: shared types, constants and the CORDIC angle table.
package mch_pkg;

	localparam logic [31:0] DEG180 = 32'd11796480;
	localparam logic [31:0] DEG360 = 32'd23592960;
	localparam logic [14:0] HEAD_MAX = 15'd23040;
	localparam logic [15:0] GAIN_ONE = 16'd4096;
	localparam logic [0:0] KIND_CAL = 1'b0;
	localparam logic [0:0] KIND_MEAS = 1'b1;
	localparam logic [0:0] REG_THRESHOLD = 1'b0;
	localparam logic [0:0] REG_CPUT = 1'b1;

	typedef struct packed {
		logic [0:0] kind;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		logic signed [15:0] raw_z;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN_Y,
		ST_GAIN_Z,
		ST_CORR,
		ST_DIV,
		ST_CORDIC,
		ST_OUT
	} state_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'd2949120;
			5'd1: r = 32'd1740967;
			5'd2: r = 32'd919879;
			5'd3: r = 32'd466945;
			5'd4: r = 32'd234379;
			5'd5: r = 32'd117304;
			5'd6: r = 32'd58666;
			5'd7: r = 32'd29335;
			5'd8: r = 32'd14668;
			5'd9: r = 32'd7334;
			5'd10: r = 32'd3667;
			5'd11: r = 32'd1833;
			5'd12: r = 32'd917;
			5'd13: r = 32'd458;
			5'd14: r = 32'd229;
			5'd15: r = 32'd115;
			5'd16: r = 32'd57;
			5'd17: r = 32'd29;
			5'd18: r = 32'd14;
			5'd19: r = 32'd7;
			5'd20: r = 32'd4;
			5'd21: r = 32'd2;
			5'd22: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/mch_fifo.sv
// Short request queue between the intake and the execution engine.
module mch_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mch_pkg::item_t in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output mch_pkg::item_t out_item
);
	import mch_pkg::*;

	item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

FILE: rtl/mch_engine.sv
// Execution engine: calibration window, correction, division and CORDIC heading.
module mch_engine #(
	parameter int CAL_SAMPLES = 101,
	parameter int CORDIC_STEPS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [0:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic           in_valid,
	output logic           in_ready,
	input  mch_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [63:0]    out_data,
	output logic           out_last
);
	import mch_pkg::*;

	localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

	state_t state_q, state_n;
	logic [15:0] thr_q, cpu_q;
	logic signed [15:0] max_q [3];
	logic signed [15:0] min_q [3];
	logic signed [15:0] off_q [3];
	logic [15:0] gy_q, gz_q;
	logic [CNT_W-1:0] cnt_q;

	// shared restoring divider
	logic [31:0] dq_q;   // dividend / quotient shift register
	logic [16:0] rem_q;
	logic [16:0] dvs_q;
	logic [5:0] dstep_q;
	logic [1:0] axis_q;
	logic [15:0] span_x_q;
	logic [15:0] span_y_q, span_z_q;

	item_t item_q;
	logic signed [15:0] c_q [3];
	logic signed [15:0] f_q [3];
	logic signed [17:0] cx_q, cy_q;
	logic signed [32:0] z_q;
	logic [4:0] it_q;
	logic zero_y_q;
	logic [14:0] head_q;
	logic done_q;
	logic busy_div;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_last = done_q;
	// 16x3 fields + 15 bit heading packed
	assign out_data = {1'b0, head_q, f_q[2], f_q[1], f_q[0]};

	// divider step
	logic [16:0] rshift;
	logic [16:0] rsub;
	assign rshift = {rem_q[15:0], dq_q[31]};
	assign rsub = rshift - dvs_q;
	assign busy_div = (dstep_q != 6'd0);

	// correction product
	logic signed [33:0] prod;
	logic signed [33:0] pq;
	logic [15:0] gsel;
	assign gsel = (axis_q == 2'd0) ? GAIN_ONE : (axis_q == 2'd1) ? gy_q : gz_q;

	logic signed [15:0] rsel, osel;
	always_comb begin
		unique case (axis_q)
			2'd0: begin rsel = item_q.raw_x; osel = off_q[0]; end
			2'd1: begin rsel = item_q.raw_y; osel = off_q[1]; end
			default: begin rsel = item_q.raw_z; osel = off_q[2]; end
		endcase
	end
	logic signed [16:0] d2;
	assign d2 = {rsel[15], rsel} - {osel[15], osel};
	assign prod = d2 * $signed({1'b0, gsel});
	// truncate toward zero
	assign pq = (prod < 0) ? -((-prod) >>> 12) : (prod >>> 12);
	logic signed [15:0] csat;
	assign csat = (pq > 34'sd32767) ? 16'sh7fff :
		(pq < -34'sd32768) ? 16'sh8000 : pq[15:0];

	// cordic step
	logic signed [17:0] xs, ys;
	logic [31:0] at;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign at = atan_entry(it_q);

	logic signed [33:0] vsum;
	logic [33:0] vcl;
	assign vsum = {z_q[32], z_q} + $signed({2'b0, DEG180});
	always_comb begin
		if (vsum < 0) vcl = 34'd0;
		else if (vsum > $signed({2'b0, DEG360})) vcl = {2'b0, DEG360};
		else vcl = vsum;
	end
	logic [23:0] hcalc;
	assign hcalc = 24'((vcl + 34'd512) >> 10);

	logic signed [15:0] cs;
	assign cs = c_q[axis_q];

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_n = in_item.kind == KIND_CAL ? ST_IDLE : ST_CORR;
			ST_GAIN_Y, ST_GAIN_Z: ;
			ST_CORR: if (axis_q == 2'd2) state_n = ST_DIV;
			ST_DIV: if (dstep_q == 6'd1 && axis_q == 2'd2) state_n = ST_CORDIC;
			ST_CORDIC: if (zero_y_q || it_q == 5'(STEPS)) state_n = ST_OUT;
			ST_OUT: if (out_ready) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
		if (state_q == ST_IDLE && in_valid && in_item.kind == KIND_CAL) begin
			state_n = (cnt_q == CNT_W'(CAL_SAMPLES - 1)) ? ST_GAIN_Y : ST_OUT;
		end
		if (state_q == ST_GAIN_Y && dstep_q == 6'd1) state_n = ST_GAIN_Z;
		if (state_q == ST_GAIN_Z && dstep_q == 6'd1) state_n = ST_OUT;
	end

	logic [15:0] sp [3];
	always_comb begin
		for (int k = 0; k < 3; k++) sp[k] = 16'(max_q[k] - min_q[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_q <= 16'd0;
			cpu_q <= 16'd1;
			gy_q <= GAIN_ONE;
			gz_q <= GAIN_ONE;
			cnt_q <= '0;
			done_q <= 1'b0;
			dstep_q <= 6'd0;
			for (int k = 0; k < 3; k++) begin
				max_q[k] <= '0;
				min_q[k] <= '0;
				off_q[k] <= '0;
			end
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				if (cfg_index == REG_THRESHOLD) thr_q <= cfg_data;
				else cpu_q <= cfg_data;
			end
			// last step is taken combinationally by the state that owns the divide
			if (busy_div && dstep_q != 6'd1) begin
				dstep_q <= dstep_q - 6'd1;
				if (!rsub[16]) begin
					rem_q <= rsub;
					dq_q <= {dq_q[30:0], 1'b1};
				end else begin
					rem_q <= rshift;
					dq_q <= {dq_q[30:0], 1'b0};
				end
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					item_q <= in_item;
					done_q <= 1'b0;
					head_q <= '0;
					axis_q <= 2'd0;
					for (int k = 0; k < 3; k++) f_q[k] <= '0;
					if (in_item.kind == KIND_CAL) begin
						logic signed [15:0] r [3];
						logic signed [15:0] mx [3];
						logic signed [15:0] mn [3];
						r[0] = in_item.raw_x; r[1] = in_item.raw_y; r[2] = in_item.raw_z;
						for (int k = 0; k < 3; k++) begin
							if (cnt_q == '0) begin
								mx[k] = r[k]; mn[k] = r[k];
							end else begin
								mx[k] = (r[k] > max_q[k]) ? r[k] : max_q[k];
								mn[k] = (r[k] < min_q[k]) ? r[k] : min_q[k];
							end
							max_q[k] <= mx[k];
							min_q[k] <= mn[k];
						end
						if (cnt_q == '0) for (int k = 0; k < 3; k++) off_q[k] <= '0;
						if (cnt_q == CNT_W'(CAL_SAMPLES - 1)) begin
							cnt_q <= '0;
							done_q <= 1'b1;
							span_x_q <= 16'(mx[0] - mn[0]);
							span_y_q <= 16'(mx[1] - mn[1]);
							span_z_q <= 16'(mx[2] - mn[2]);
							dq_q <= {16'(mx[0] - mn[0]), 16'd0} >> 4;
							rem_q <= '0;
							dvs_q <= {1'b0, 16'(mx[1] - mn[1])};
							dstep_q <= 6'd32;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_GAIN_Y: begin
					if (dstep_q == 6'd1) begin
						logic [31:0] qv;
						qv = rsub[16] ? {dq_q[30:0], 1'b0} : {dq_q[30:0], 1'b1};
						gy_q <= (span_y_q == 16'd0) ? GAIN_ONE :
							(qv > 32'd65535) ? 16'hffff : qv[15:0];
						dq_q <= {span_x_q, 16'd0} >> 4;
						rem_q <= '0;
						dvs_q <= {1'b0, span_z_q};
						dstep_q <= 6'd32;
						for (int k = 0; k < 3; k++) begin
							logic signed [16:0] s;
							s = {max_q[k][15], max_q[k]} + {min_q[k][15], min_q[k]};
							off_q[k] <= (sp[k] > thr_q) ?
								16'((s < 0) ? -((-s) >>> 1) : (s >>> 1)) : 16'd0;
						end
					end
				end
				ST_GAIN_Z: begin
					if (dstep_q == 6'd1) begin
						logic [31:0] qz;
						qz = rsub[16] ? {dq_q[30:0], 1'b0} : {dq_q[30:0], 1'b1};
						gz_q <= (span_z_q == 16'd0) ? GAIN_ONE :
							(qz > 32'd65535) ? 16'hffff : qz[15:0];
						dstep_q <= 6'd0;
					end
				end
				ST_CORR: begin
					c_q[axis_q] <= csat;
					if (axis_q == 2'd2) axis_q <= 2'd0;
					else axis_q <= axis_q + 2'd1;
					if (axis_q == 2'd2) begin
						logic [15:0] m0;
						m0 = c_q[0][15] ? 16'(-c_q[0]) : c_q[0];
						dq_q <= {m0, 16'd0};
						rem_q <= '0;
						dvs_q <= {1'b0, (cpu_q == 16'd0) ? 16'd1 : cpu_q};
						dstep_q <= 6'd16;
					end
				end
				ST_DIV: begin
					if (dstep_q == 6'd1) begin
						logic [15:0] qd;
						logic [15:0] nm;
						qd = {dq_q[14:0], ~rsub[16]};
						f_q[axis_q] <= cs[15] ? 16'(-qd) : qd;
						if (axis_q != 2'd2) begin
							axis_q <= axis_q + 2'd1;
							nm = c_q[axis_q + 2'd1][15] ?
								16'(-c_q[axis_q + 2'd1]) : c_q[axis_q + 2'd1];
							dq_q <= {nm, 16'd0};
							rem_q <= '0;
							dstep_q <= 6'd16;
						end else begin
							dstep_q <= 6'd0;
							it_q <= '0;
							zero_y_q <= (c_q[1] == 16'sd0);
							if (c_q[1] == 16'sd0) begin
								z_q <= c_q[0][15] ? {1'b0, DEG180} : 33'sd0;
							end else if (c_q[0][15]) begin
								z_q <= c_q[1][15] ? -$signed({1'b0, DEG180}) :
									$signed({1'b0, DEG180});
								cx_q <= -{{2{c_q[0][15]}}, c_q[0]};
								cy_q <= -{{2{c_q[1][15]}}, c_q[1]};
							end else begin
								z_q <= '0;
								cx_q <= {{2{c_q[0][15]}}, c_q[0]};
								cy_q <= {{2{c_q[1][15]}}, c_q[1]};
							end
						end
					end
				end
				ST_CORDIC: begin
					if (!zero_y_q && it_q != 5'(STEPS)) begin
						if (cy_q > 0) begin
							cx_q <= cx_q + ys; cy_q <= cy_q - xs;
							z_q <= z_q + $signed({1'b0, at});
						end else begin
							cx_q <= cx_q - ys; cy_q <= cy_q + xs;
							z_q <= z_q - $signed({1'b0, at});
						end
						it_q <= it_q + 5'd1;
					end
				end
				ST_OUT: ;
				default: ;
			endcase
			// final heading uses the value after the last CORDIC update
			if (state_n == ST_OUT && state_q == ST_CORDIC) begin
				head_q <= (hcalc > {9'd0, HEAD_MAX}) ? HEAD_MAX : hcalc[14:0];
			end
		end
	end
endmodule

FILE: rtl/magnetometer_calibrate_heading_top.sv
// Top level: request queue followed by the calibration and heading engine.
// Calibration item: updates the window; the window-closing item also runs the Y and Z gain divides.
// Measurement item: queue, correction of each axis, division of each axis, CORDIC iterations
// (skipped when corrected Y is zero) and output; one item at a time.
// The shared restoring divider and the iterative CORDIC set the rate.
// arst_n clears the window, offsets, threshold and state, sets gains to 1.0 and CPUT to 1 at once.
module magnetometer_calibrate_heading_top #(
	parameter int CAL_SAMPLES = 101,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // raw_x, raw_y, raw_z
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // field_x, field_y, field_z, heading, pad
	output logic        m_tlast    // calibration_done
);
	import mch_pkg::*;

	item_t in_item, q_item;
	logic q_valid, q_ready;

	assign in_item.kind = s_tuser;
	assign in_item.raw_x = s_tdata[15:0];
	assign in_item.raw_y = s_tdata[31:16];
	assign in_item.raw_z = s_tdata[47:32];

	mch_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	mch_engine #(.CAL_SAMPLES(CAL_SAMPLES), .CORDIC_STEPS(CORDIC_STEPS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_data(m_tdata), .out_last(m_tlast)
	);
endmodule

FILE: tb/magnetometer_calibrate_heading_top_test.sv
// Testbench: magnetometer calibration and heading engine against an in-bench predictor.
`timescale 1ns / 100ps

module magnetometer_calibrate_heading_top_test;
	import mch_pkg::*;

	localparam int CAL_SAMPLES = 101;
	localparam int CORDIC_STEPS = 16;
	localparam longint DEG = 65536;

	typedef struct {
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic signed [15:0] fz;
		logic [14:0] hd;
		logic done;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_THRESHOLD;
	logic [15:0] cfg_data = 16'd0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = 48'd0;
	logic s_tuser = KIND_CAL;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic m_tlast;

	// predictor state
	int threshold_q = 0;
	int cput_q = 1;
	int amax[3], amin[3], aoff[3];
	int gain_y = 4096, gain_z = 4096;
	int win_count = 0;

	reading_t pending_readings[$];
	int mismatches = 0;
	bit sink_quiet = 0;
	bit source_quiet = 0;
	int sink_stall = 0;

	magnetometer_calibrate_heading_top #(
		.CAL_SAMPLES(CAL_SAMPLES),
		.CORDIC_STEPS(CORDIC_STEPS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("magnetometer_calibrate_heading_top: mismatch");
		$finish;
	end

	function automatic int sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	function automatic int correct_axis(int raw, int off, int gain);
		longint p;
		p = longint'(raw - off) * longint'(gain);
		return sat16(p / 4096);
	endfunction

	function automatic int span_gain(int sx, int sa);
		longint g;
		if (sa == 0) return 4096;
		g = (longint'(sx) * 4096) / longint'(sa);
		return g > 65535 ? 65535 : int'(g);
	endfunction

	// vectoring CORDIC, result in 1/65536 degree
	function automatic longint bearing(longint x, longint y);
		longint z, xs, ys;
		int steps;
		z = 0;
		if (y == 0) return x >= 0 ? 0 : 180 * DEG;
		if (x < 0) begin
			z = (y >= 0) ? 180 * DEG : -180 * DEG;
			x = -x;
			y = -y;
		end
		steps = CORDIC_STEPS > 24 ? 24 : CORDIC_STEPS;
		for (int i = 0; i < steps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z = z + longint'(atan_entry(5'(i)));
			end else begin
				x = x - ys; y = y + xs; z = z - longint'(atan_entry(5'(i)));
			end
		end
		return z;
	endfunction

	function automatic void predict_reading(logic kind, logic signed [15:0] rx,
			logic signed [15:0] ry, logic signed [15:0] rz);
		reading_t r;
		int raw[3], span[3], cx, cy, cz, dv;
		longint v, h;
		raw[0] = rx; raw[1] = ry; raw[2] = rz;
		r = '{fx: 0, fy: 0, fz: 0, hd: 0, done: 0};
		if (kind == KIND_CAL) begin
			for (int k = 0; k < 3; k++) begin
				if (win_count == 0) begin
					amax[k] = raw[k]; amin[k] = raw[k]; aoff[k] = 0;
				end else begin
					if (raw[k] > amax[k]) amax[k] = raw[k];
					if (raw[k] < amin[k]) amin[k] = raw[k];
				end
			end
			win_count++;
			if (win_count >= CAL_SAMPLES) begin
				for (int k = 0; k < 3; k++) begin
					span[k] = amax[k] - amin[k];
					aoff[k] = span[k] > threshold_q ? (amax[k] + amin[k]) / 2 : 0;
				end
				gain_y = span_gain(span[0], span[1]);
				gain_z = span_gain(span[0], span[2]);
				win_count = 0;
				r.done = 1;
			end
		end else begin
			cx = correct_axis(raw[0], aoff[0], 4096);
			cy = correct_axis(raw[1], aoff[1], gain_y);
			cz = correct_axis(raw[2], aoff[2], gain_z);
			dv = cput_q == 0 ? 1 : cput_q;
			r.fx = 16'(cx / dv);
			r.fy = 16'(cy / dv);
			r.fz = 16'(cz / dv);
			v = bearing(cx, cy) + 180 * DEG;
			if (v < 0) v = 0;
			if (v > 360 * DEG) v = 360 * DEG;
			h = (v + 512) >>> 10;
			if (h > 23040) h = 23040;
			r.hd = 15'(h);
		end
		pending_readings.push_back(r);
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// result checker and sink stall
	always @(posedge clk) begin
		reading_t e;
		if (m_tvalid && m_tready) begin
			if (pending_readings.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				e = pending_readings.pop_front();
				if (m_tdata[15:0] !== e.fx) report("field_x", $signed(m_tdata[15:0]), e.fx);
				if (m_tdata[31:16] !== e.fy) report("field_y", $signed(m_tdata[31:16]), e.fy);
				if (m_tdata[47:32] !== e.fz) report("field_z", $signed(m_tdata[47:32]), e.fz);
				if (m_tdata[62:48] !== e.hd) report("heading", m_tdata[62:48], e.hd);
				if (m_tlast !== e.done) report("calibration_done", m_tlast, e.done);
			end
			sink_stall = sink_quiet ? 0 : $urandom_range(13, 0);
		end
		if (sink_stall > 0) begin
			sink_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_sample(logic kind, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {rz, ry, rx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_reading(kind, rx, ry, rz);
		gap = source_quiet ? 0 : $urandom_range(13, 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid at the accepting edge so the last request is not taken twice
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_THRESHOLD) threshold_q = val;
		else cput_q = val;
	endtask

	// values near the current offset so gains and small headings get exercised
	function automatic int aoff_pick(int k);
		return aoff[k] + int'($urandom_range(400, 0)) - 200;
	endfunction

	// reset-state gains and offsets, axis and sign extremes
	task automatic test_axis_extremes;
		send_sample(KIND_MEAS, 16'd0, 16'd0, 16'd0);
		send_sample(KIND_MEAS, 16'h8000, 16'd0, 16'd0);
		send_sample(KIND_MEAS, 16'd5, 16'd0, 16'h7fff);
		send_sample(KIND_MEAS, 16'h7fff, 16'h7fff, 16'h8000);
		send_sample(KIND_MEAS, 16'h8000, 16'h8000, 16'h7fff);
		send_sample(KIND_MEAS, 16'h8000, 16'h0001, 16'hffff);
		send_sample(KIND_MEAS, 16'hffff, 16'hffff, 16'd0);
		send_sample(KIND_MEAS, 16'd0, 16'h7fff, 16'd1);
		send_sample(KIND_MEAS, 16'd0, 16'h8000, 16'd1);
		send_sample(KIND_MEAS, 16'h7fff, 16'hffff, 16'd3);
		drain();
	endtask

	// divisor extremes, zero acting as one
	task automatic test_divisor;
		write_reg(REG_CPUT, 0);
		send_sample(KIND_MEAS, 16'h7fff, 16'h8000, 16'h1234);
		drain();
		write_reg(REG_CPUT, 65535);
		send_sample(KIND_MEAS, 16'h7fff, 16'h8000, 16'h8000);
		send_sample(KIND_MEAS, 16'h1000, 16'hf000, 16'h0001);
		drain();
		write_reg(REG_CPUT, 7);
		send_sample(KIND_MEAS, 16'h8001, 16'h0064, 16'hff9c);
		drain();
	endtask

	// one window with drawn per-axis bounds, measurements mixed in and after
	task automatic test_window(int thr, int cput, bit quiet);
		int lo[3], hi[3], mode, a, b, sent;
		logic [15:0] s[3];
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_CPUT, cput);
		source_quiet = quiet;
		sink_quiet = quiet;
		for (int k = 0; k < 3; k++) begin
			mode = $urandom_range(4, 0);
			a = $signed(16'($urandom));
			b = $signed(16'($urandom));
			if (a > b) begin lo[k] = b; hi[k] = a; end
			else begin lo[k] = a; hi[k] = b; end
			if (mode == 0) hi[k] = lo[k];
			else if (mode == 1) hi[k] = lo[k] + (lo[k] < 32767);
			else if (mode == 2) begin lo[k] = -32768; hi[k] = 32767; end
			else if (mode == 3 && hi[k] - lo[k] > 600) hi[k] = lo[k] + $urandom_range(600, 0);
		end
		sent = 0;
		while (sent < CAL_SAMPLES) begin
			if ($urandom_range(9, 0) == 0) begin
				send_sample(KIND_MEAS, 16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				for (int k = 0; k < 3; k++) begin
					if (sent == 0) s[k] = 16'(lo[k]);
					else if (sent == 1) s[k] = 16'(hi[k]);
					else s[k] = 16'(lo[k] + int'($urandom_range(hi[k] - lo[k], 0)));
				end
				send_sample(KIND_CAL, s[0], s[1], s[2]);
				sent++;
			end
		end
		for (int n = 0; n < 10; n++) begin
			if ($urandom_range(1, 0))
				send_sample(KIND_MEAS, 16'($urandom), 16'($urandom), 16'($urandom));
			else
				send_sample(KIND_MEAS, 16'(aoff_pick(0)), 16'(aoff_pick(1)), 16'(aoff_pick(2)));
		end
		drain();
		source_quiet = 0;
		sink_quiet = 0;
	endtask

	initial begin
		for (int k = 0; k < 3; k++) begin
			amax[k] = 0; amin[k] = 0; aoff[k] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_axis_extremes();
		test_divisor();
		test_window(0, 1, 1'b0);
		test_window(65535, 65535, 1'b0);
		test_window($urandom_range(2000, 0), 0, 1'b1);
		test_window($urandom_range(65535, 0), $urandom_range(20, 1), 1'b0);
		test_window(100, 3, 1'b0);
		if (mismatches == 0) begin
			$display("magnetometer_calibrate_heading_top: match");
		end else begin
			$display("magnetometer_calibrate_heading_top: mismatch");
		end
		$finish;
	end

endmodule
